// ===== rtl/irn_pkg.sv =====
// Shared constants, lookup tables, types and codes of the infrared normalizer.
package irn_pkg;

    // Default store geometry handed to the top level.
    localparam int SENSOR_ROWS_DEF = 4;
    localparam int SENSOR_COLS_DEF = 32;

    // Field widths.
    localparam int SAMPLE_BITS = 8;
    localparam int KIND_W      = 2;
    localparam int BADDR_W     = 8;
    localparam int IDX_W       = 3;
    localparam int RAW_W       = 8;
    localparam int ROW_W       = 2;
    localparam int COL_W       = 5;
    localparam int CAL_W       = 8;
    localparam int VAL_W       = 9;

    // Scaling constants.
    localparam int MIN_SPAN  = 96;
    localparam int SCALE_TOP = 99;
    localparam int SCALE_W   = 7;
    localparam int NUM_W     = SAMPLE_BITS + SCALE_W;
    localparam int QUO_W     = VAL_W;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_MIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_MAX = 2'd2;

    // Board table.
    localparam int BOARD_COUNT = 7;
    localparam int BOARD_W     = 3;
    localparam int MAP_DEPTH   = BOARD_COUNT * 8;
    localparam int MAP_IDX_W   = BOARD_W + IDX_W;

    localparam logic [BADDR_W-1:0] BOARD_ADDR [BOARD_COUNT] = '{
        8'h20, 8'h21, 8'h22, 8'h30, 8'h31, 8'h32, 8'h33
    };

    localparam logic [ROW_W-1:0] ROW_TAB [MAP_DEPTH] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1
    };

    localparam logic [COL_W-1:0] COL_TAB [MAP_DEPTH] = '{
        5'd20, 5'd21, 5'd22, 5'd23, 5'd0,  5'd1,  5'd2,  5'd3,
        5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
        5'd23, 5'd0,  5'd0,  5'd1,  5'd2,  5'd3,  5'd1,  5'd4,
        5'd5,  5'd6,  5'd2,  5'd7,  5'd8,  5'd9,  5'd3,  5'd10,
        5'd11, 5'd12, 5'd4,  5'd13, 5'd14, 5'd15, 5'd5,  5'd16,
        5'd17, 5'd18, 5'd6,  5'd19, 5'd20, 5'd21, 5'd7,  5'd22
    };

    typedef struct packed {
        logic               hit;
        logic [BOARD_W-1:0] num;
    } board_hit_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic out_load;
    } irn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sample;
        logic need_div;
        logic out_free;
    } irn_sts_t;

    // Search the board table for a bus address.
    function automatic board_hit_t find_board(input logic [BADDR_W-1:0] addr);
        board_hit_t res;
        res.hit = 1'b0;
        res.num = '0;
        for (int i = 0; i < BOARD_COUNT; i++) begin
            if (BOARD_ADDR[i] == addr) begin
                res.hit = 1'b1;
                res.num = BOARD_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/irn_cal_store.sv =====
// Calibration minimum and maximum memories with per-entry valid bits.
module irn_cal_store
    import irn_pkg::*;
#(
    parameter int SENSOR_ROWS = SENSOR_ROWS_DEF,
    parameter int SENSOR_COLS = SENSOR_COLS_DEF,
    localparam int DEPTH  = SENSOR_ROWS * SENSOR_COLS,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic              wr_max,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CAL_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CAL_W-1:0]  rd_min,
    output logic [CAL_W-1:0]  rd_max
);

    logic [CAL_W-1:0] min_mem [DEPTH];
    logic [CAL_W-1:0] max_mem [DEPTH];
    logic [DEPTH-1:0] min_vld_reg;
    logic [DEPTH-1:0] max_vld_reg;
    logic [CAL_W-1:0] min_data_reg;
    logic [CAL_W-1:0] max_data_reg;
    logic             min_hit_reg;
    logic             max_hit_reg;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_max)
        begin
            min_mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_max)
        begin
            max_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            min_data_reg <= min_mem[rd_addr];
            max_data_reg <= max_mem[rd_addr];
        end
    end

    // Valid bits stand in for the all-zero reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_vld_reg <= '0;
            max_vld_reg <= '0;
            min_hit_reg <= 1'b0;
            max_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && !wr_max)
            begin
                min_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && wr_max)
            begin
                max_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                min_hit_reg <= min_vld_reg[rd_addr];
                max_hit_reg <= max_vld_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as zero.
    assign rd_min = min_hit_reg ? min_data_reg : '0;
    assign rd_max = max_hit_reg ? max_data_reg : '0;

endmodule

// ===== rtl/irn_divider.sv =====
// Restoring divider that produces one quotient bit per step.
module irn_divider
    import irn_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [NUM_W-1:0] num,
    input  logic [CAL_W-1:0] den,
    output logic [QUO_W-1:0] quot,
    output logic             ovf
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [CAL_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [CAL_W-1:0] den_reg,  den_next;
    logic             ovf_reg,  ovf_next;
    logic [CAL_W:0]   shifted;
    logic [CAL_W:0]   trial;
    logic             take;

    // One shift-subtract step, or a fresh load of the dividend.
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[QUO_W-1]};
        trial     = shifted - {1'b0, den_reg};
        take      = !trial[CAL_W];
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (load)
        begin
            // The upper dividend bits seed the remainder; if they already reach the
            // divisor, the quotient does not fit and the result saturates.
            rem_next  = CAL_W'(num[NUM_W-1:QUO_W]);
            quot_next = num[QUO_W-1:0];
            den_next  = den;
            ovf_next  = ({{CAL_W{1'b0}}, num[NUM_W-1:QUO_W]} >= {{HI_W{1'b0}}, den});
        end
        else if (step)
        begin
            rem_next  = take ? trial[CAL_W-1:0] : shifted[CAL_W-1:0];
            quot_next = {quot_reg[QUO_W-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        ovf_reg  <= ovf_next;
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== rtl/irn_datapath.sv =====
// Datapath: board lookup, calibration store, scaling, divider and output register.
module irn_datapath
    import irn_pkg::*;
#(
    parameter int SENSOR_ROWS = SENSOR_ROWS_DEF,
    parameter int SENSOR_COLS = SENSOR_COLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  irn_cmd_t           cmd,
    output irn_sts_t           sts,
    input  logic               cfg_we,
    input  logic               cfg_enable,
    input  logic [KIND_W-1:0]  kind,
    input  logic [BADDR_W-1:0] board_address,
    input  logic [IDX_W-1:0]   sensor_index,
    input  logic [RAW_W-1:0]   raw_sample,
    input  logic [ROW_W-1:0]   load_row,
    input  logic [COL_W-1:0]   load_col,
    input  logic [CAL_W-1:0]   load_value,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [ROW_W-1:0]   sensor_row,
    output logic [COL_W-1:0]   sensor_col,
    output logic [VAL_W-1:0]   scaled_value,
    output logic               bad_address
);

    localparam int ADDR_W = $clog2(SENSOR_ROWS * SENSOR_COLS);

    logic                   enable_reg;
    board_hit_t             board;
    logic [MAP_IDX_W-1:0]   map_idx;
    logic [ROW_W-1:0]       map_row;
    logic [COL_W-1:0]       map_col;
    logic                   map_in_range;
    logic                   load_in_range;
    logic                   is_load;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [CAL_W-1:0]       rd_min;
    logic [CAL_W-1:0]       rd_max;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic                   bad_reg;
    logic                   in_range_reg;

    logic [CAL_W-1:0]       lo;
    logic [CAL_W-1:0]       hi;
    logic [CAL_W:0]         span;
    logic                   span_low;
    logic                   zero_norm;
    logic [SAMPLE_BITS-1:0] diff;
    logic [NUM_W-1:0]       num;
    logic                   zero_reg;
    logic                   pass_reg;
    logic [QUO_W-1:0]       quot;
    logic                   ovf;

    logic                   out_valid_reg;
    logic [ROW_W-1:0]       out_row_reg;
    logic [COL_W-1:0]       out_col_reg;
    logic [VAL_W-1:0]       out_val_reg;
    logic [VAL_W-1:0]       out_val_next;
    logic                   out_bad_reg;

    // Normalize enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_enable;
        end
    end

    // Board and sensor position lookup on the incoming word.
    always_comb
    begin
        board         = find_board(board_address);
        map_idx       = {board.num, sensor_index};
        map_row       = ROW_TAB[map_idx];
        map_col       = COL_TAB[map_idx];
        map_in_range  = (32'(map_row) < SENSOR_ROWS) && (32'(map_col) < SENSOR_COLS);
        load_in_range = (32'(load_row) < SENSOR_ROWS) && (32'(load_col) < SENSOR_COLS);
        rd_addr       = ADDR_W'(32'(map_row) * SENSOR_COLS + 32'(map_col));
        wr_addr       = ADDR_W'(32'(load_row) * SENSOR_COLS + 32'(load_col));
        is_load       = (kind == KIND_LOAD_MIN) || (kind == KIND_LOAD_MAX);
    end

    irn_cal_store #(
        .SENSOR_ROWS (SENSOR_ROWS),
        .SENSOR_COLS (SENSOR_COLS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd.accept && is_load && load_in_range),
        .wr_max  (kind == KIND_LOAD_MAX),
        .wr_addr (wr_addr),
        .wr_data (load_value),
        .rd_en   (cmd.accept && sts.is_sample),
        .rd_addr (rd_addr),
        .rd_min  (rd_min),
        .rd_max  (rd_max)
    );

    // Capture the sample word when it is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.is_sample)
        begin
            sample_reg   <= raw_sample[SAMPLE_BITS-1:0];
            row_reg      <= board.hit ? map_row : '0;
            col_reg      <= board.hit ? map_col : '0;
            bad_reg      <= !board.hit;
            in_range_reg <= board.hit && map_in_range;
        end
    end

    // Span checks and the scaled numerator.
    always_comb
    begin
        lo        = in_range_reg ? rd_min : '0;
        hi        = in_range_reg ? rd_max : '0;
        span      = {1'b0, hi} - {1'b0, lo};
        span_low  = span[CAL_W] || (span[CAL_W-1:0] < CAL_W'(MIN_SPAN));
        zero_norm = (hi == '0) || span_low || (sample_reg <= SAMPLE_BITS'(lo));
        diff      = sample_reg - SAMPLE_BITS'(lo);
        num       = NUM_W'(diff) * NUM_W'(SCALE_TOP);
    end

    // Result selection flags, fixed once the calibration is known.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            zero_reg <= bad_reg || (enable_reg && zero_norm);
            pass_reg <= !enable_reg;
        end
    end

    irn_divider u_div (
        .clk  (clk),
        .load (cmd.prep),
        .step (cmd.div_step),
        .num  (num),
        .den  (span[CAL_W-1:0]),
        .quot (quot),
        .ovf  (ovf)
    );

    // Final value of the result word.
    always_comb
    begin
        if (zero_reg)
        begin
            out_val_next = '0;
        end
        else if (pass_reg)
        begin
            out_val_next = VAL_W'(sample_reg);
        end
        else if (ovf)
        begin
            out_val_next = '1;
        end
        else
        begin
            out_val_next = quot;
        end
    end

    // Output register: holds the result word until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_val_reg <= out_val_next;
            out_bad_reg <= bad_reg;
        end
    end

    // Status for the controller.
    always_comb
    begin
        sts.is_sample = (kind == KIND_SAMPLE);
        sts.need_div  = enable_reg && !bad_reg && !zero_norm;
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign sensor_row   = out_row_reg;
    assign sensor_col   = out_col_reg;
    assign scaled_value = out_val_reg;
    assign bad_address  = out_bad_reg;

endmodule

// ===== rtl/irn_ctrl.sv =====
// Controller state machine that sequences one sample through the datapath.
module irn_ctrl
    import irn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  irn_sts_t sts,
    output irn_cmd_t cmd,
    output logic     in_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && sts.is_sample)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Words are taken only while no sample is in process.
    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/ir_sensor_calibrated_normalizer_top.sv =====
// Top level of the calibrated infrared sample normalizer.
//
// Input channel (in_valid/in_stall) carries one word per item: a sample word
// names a board address, sensor index and raw reading; a load word writes a
// calibration minimum or maximum at load_row/load_col. Load words give no
// result and do not stall the input. A sample word gives one result word on
// the output channel (out_valid/out_stall): mapped row and column, scaled
// value and a bad address flag.
// A sample holds the input stalled from when it is taken until its result is
// loaded into the output register, so a new sample enters only after that:
// the calibration memory is read as the sample is taken, the scaled numerator
// is formed and the bit-serial divider runs, then the output register is
// loaded once it is free. Samples that need no division skip the divider.
// The output register keeps a finished word while the receiver stalls, and the
// next word is taken meanwhile; a second result waits in the controller until
// the register frees.
// The configuration channel (cfg_valid/cfg_ready) writes normalize_enable; it
// is always ready. Reset clears all calibration entries to zero through valid
// bits at once, empties the output and sets normalize_enable to 1.
module ir_sensor_calibrated_normalizer_top
    import irn_pkg::*;
#(
    parameter int SENSOR_ROWS = SENSOR_ROWS_DEF,
    parameter int SENSOR_COLS = SENSOR_COLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               normalize_enable,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [BADDR_W-1:0] board_address,
    input  logic [IDX_W-1:0]   sensor_index,
    input  logic [RAW_W-1:0]   raw_sample,
    input  logic [ROW_W-1:0]   load_row,
    input  logic [COL_W-1:0]   load_col,
    input  logic [CAL_W-1:0]   load_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ROW_W-1:0]   sensor_row,
    output logic [COL_W-1:0]   sensor_col,
    output logic [VAL_W-1:0]   scaled_value,
    output logic               bad_address
);

    irn_cmd_t cmd;
    irn_sts_t sts;

    // The enable register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    irn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    irn_datapath #(
        .SENSOR_ROWS (SENSOR_ROWS),
        .SENSOR_COLS (SENSOR_COLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_enable    (normalize_enable),
        .kind          (kind),
        .board_address (board_address),
        .sensor_index  (sensor_index),
        .raw_sample    (raw_sample),
        .load_row      (load_row),
        .load_col      (load_col),
        .load_value    (load_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .sensor_row    (sensor_row),
        .sensor_col    (sensor_col),
        .scaled_value  (scaled_value),
        .bad_address   (bad_address)
    );

endmodule

// ===== rtl/irn_checker.sv =====
// Port-level checker of the normalizer and its bind to the top level.
module irn_port_checker
    import irn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [KIND_W-1:0] kind,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ROW_W-1:0]  sensor_row,
    input logic [COL_W-1:0]  sensor_col,
    input logic [VAL_W-1:0]  scaled_value,
    input logic              bad_address
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scaled_value)
            && $stable(sensor_row) && $stable(sensor_col) && $stable(bad_address))
        else $error("stalled result word changed");

    // An unknown board gives an all-zero position and value.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_address |-> sensor_row == '0 && sensor_col == '0
            && scaled_value == '0)
        else $error("bad address result carries nonzero fields");

    // A taken sample word blocks the input while it is processed.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_SAMPLE |=> in_stall)
        else $error("input not stalled after a sample word");

    // Load and unused words finish in the cycle they are taken.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind != KIND_SAMPLE |=> !in_stall)
        else $error("input stalled after a non-sample word");

    // A result word appears only at the end of sample processing.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word appeared with no sample in process");

endmodule

bind ir_sensor_calibrated_normalizer_top irn_port_checker u_irn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sensor_row   (sensor_row),
    .sensor_col   (sensor_col),
    .scaled_value (scaled_value),
    .bad_address  (bad_address)
);
